FILE: src/mba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mba_pkg
// shared types, codes and defaults of the marked bump arena allocator
// ----------------------------------------------------------------------------
package mba_pkg;

    // default sizing
    localparam int DEF_MAX_LEVELS   = 16;
    localparam int DEF_MAX_SEGMENTS = 8;
    localparam int DEF_MEM_TYPES    = 6;

    // register reset values
    localparam logic [31:0] ARENA_SIZE_RST   = 32'd12570624;
    localparam logic [31:0] SEGMENT_SIZE_RST = 32'd0;

    localparam logic [31:0] ALIGN_MASK = 32'h0000_001F;
    localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic CFG_ARENA_SIZE   = 1'b0;
    localparam logic CFG_SEGMENT_SIZE = 1'b1;

    // item kinds
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_MARK    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEM    = 2'd1;
    localparam logic [1:0] ST_LVL_OVF   = 2'd2;
    localparam logic [1:0] ST_BAD_LEVEL = 2'd3;

    // placement walker result
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [31:0] where;
    } walk_res_t;

endpackage
`default_nettype wire

FILE: src/mba_cnt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mba_cnt_mem
// counter row memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module mba_cnt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: src/mba_seg_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mba_seg_walker
// placement unit, checks one segment per cycle for room for the block, or the whole arena when the segment size is zero
// ----------------------------------------------------------------------------
module mba_seg_walker #(
    parameter int MAX_SEGMENTS = 8,
    parameter int IDX_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [31:0]       used,
    input  wire logic [31:0]       size,
    input  wire logic [31:0]       arena,
    input  wire logic [31:0]       seg_size,
    output mba_pkg::walk_res_t     res,
    output logic      [IDX_W-1:0]  seg_idx
);

    import mba_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEGMENTS);

    logic             active_reg,  active_next;
    logic [33:0]      logical_reg, logical_next;
    logic [33:0]      start_reg,   start_next;
    logic [IDX_W-1:0] idx_reg,     idx_next;
    logic             done_reg,    done_next;
    logic             ok_reg,      ok_next;
    logic [31:0]      where_reg,   where_next;
    logic [IDX_W-1:0] seg_reg,     seg_next;

    logic [33:0] arena_w;
    logic [33:0] end_raw;
    logic [33:0] end_c;
    logic [33:0] lg;
    logic [33:0] room;
    logic [34:0] flat_end;

    always_comb
    begin
        arena_w  = {2'b00, arena};
        end_raw  = start_reg + {2'b00, seg_size};
        end_c    = (end_raw > arena_w) ? arena_w : end_raw;
        lg       = (logical_reg < start_reg) ? start_reg : logical_reg;
        room     = end_c - lg;
        flat_end = {1'b0, logical_reg} + {3'b000, size};
    end

    always_comb
    begin
        active_next  = active_reg;
        logical_next = logical_reg;
        start_next   = start_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        where_next   = where_reg;
        seg_next     = seg_reg;

        if (go)
        begin
            active_next  = 1'b1;
            logical_next = ({2'b00, used} + {2'b00, ALIGN_MASK}) & ~{2'b00, ALIGN_MASK};
            start_next   = '0;
            idx_next     = '0;
        end
        else if (active_reg)
        begin
            if (seg_size == '0)
            begin
                // one unbroken arena
                active_next = 1'b0;
                done_next   = 1'b1;
                ok_next     = (flat_end <= {1'b0, arena_w});
                where_next  = logical_reg[31:0];
                seg_next    = '0;
            end
            else if ((idx_reg == LAST_IDX) || (start_reg >= arena_w))
            begin
                // ran out of segments
                active_next = 1'b0;
                done_next   = 1'b1;
                ok_next     = 1'b0;
            end
            else if (lg >= end_c)
            begin
                logical_next = lg;
                start_next   = end_raw;
                idx_next     = idx_reg + 1'b1;
            end
            else if ({2'b00, size} <= room)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
                ok_next     = 1'b1;
                where_next  = lg[31:0];
                seg_next    = idx_reg;
            end
            else
            begin
                // skip the tail of a segment too small for the block
                logical_next = end_c;
                start_next   = end_raw;
                idx_next     = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        logical_reg <= logical_next;
        start_reg   <= start_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        where_reg   <= where_next;
        seg_reg     <= seg_next;
    end

    assign res.done = done_reg;
    assign res.ok   = ok_reg;
    assign res.where = where_reg;
    assign seg_idx  = seg_reg;

endmodule
`default_nettype wire

FILE: src/marked_bump_arena_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// marked_bump_arena_allocator
// bump allocator over a linear arena with mark and release levels
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; each command
// gives exactly one result, shown for a single cycle with done high, and the
// receiver must take it then since there is no way to stall it. Mark and
// release answer in the cycle after the transfer. A query of a stored counter
// passes through S_QREAD, which reads the counter row memory, and S_QDONE,
// which takes its registered data; an out-of-range query answers in the
// next cycle. An alloc runs the placement walker, which looks at one
// segment per cycle, or at the whole arena when segment_size is zero; a
// placed block of a memory type with a counter then goes through the
// counter row read-modify-write in S_CREAD and S_CWRITE. busy stays high
// until the result is out. Counters sit in a row-wide memory, one row per
// level, with one valid bit per row, so reset and mark clear counters at
// once.
// ----------------------------------------------------------------------------
module marked_bump_arena_allocator #(
    parameter int MAX_LEVELS   = mba_pkg::DEF_MAX_LEVELS,
    parameter int MAX_SEGMENTS = mba_pkg::DEF_MAX_SEGMENTS,
    parameter int MEM_TYPES    = mba_pkg::DEF_MEM_TYPES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] size,
    input  wire logic [2:0]  mem_type,
    input  wire logic [3:0]  level,
    input  wire logic [31:0] mark_used,
    // result
    output logic             done,
    output logic      [1:0]  status,
    output logic      [31:0] offset,
    output logic      [2:0]  segment,
    output logic      [3:0]  marker_level,
    output logic      [31:0] marker_used,
    output logic      [31:0] type_bytes
);

    import mba_pkg::*;

    localparam int LVL_W  = $clog2(MAX_LEVELS);
    localparam int TYPE_W = (MEM_TYPES > 1) ? $clog2(MEM_TYPES) : 1;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ROW_W  = MEM_TYPES * 32;

    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(MAX_LEVELS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_CREAD  = 3'd2;
    localparam logic [2:0] S_CWRITE = 3'd3;
    localparam logic [2:0] S_QREAD  = 3'd4;
    localparam logic [2:0] S_QDONE  = 3'd5;

    typedef logic [MEM_TYPES-1:0][31:0] row_t;

    // control state
    logic [2:0]            state_reg,     state_next;
    logic [31:0]           arena_reg,     arena_next;
    logic [31:0]           seg_size_reg,  seg_size_next;
    logic [31:0]           used_reg,      used_next;
    logic [LVL_W-1:0]      cur_lvl_reg,   cur_lvl_next;
    logic [MAX_LEVELS-1:0] row_valid_reg, row_valid_next;
    logic                  done_reg,      done_next;

    // latched command fields
    logic [31:0]           size_reg,      size_next;
    logic [TYPE_W-1:0]     lane_reg,      lane_next;
    logic [LVL_W-1:0]      qlvl_reg,      qlvl_next;

    // result registers
    logic [1:0]            status_reg,    status_next;
    logic [31:0]           offset_reg,    offset_next;
    logic [2:0]            segment_reg,   segment_next;
    logic [3:0]            mlev_reg,      mlev_next;
    logic [31:0]           mused_reg,     mused_next;
    logic [31:0]           tbytes_reg,    tbytes_next;

    logic                  accept;
    logic                  walk_go;
    walk_res_t             walk_res;
    logic [IDX_W-1:0]      walk_seg;

    logic                  mem_wr_en;
    logic [LVL_W-1:0]      mem_wr_addr;
    row_t                  mem_wr_data;
    logic                  mem_rd_en;
    logic [LVL_W-1:0]      mem_rd_addr;
    logic [ROW_W-1:0]      mem_rd_data;

    row_t                  row_eff;
    logic [32:0]           cnt_sum;
    logic [31:0]           cnt_new;
    logic                  type_ok;
    logic                  qlvl_ok;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign walk_go = accept && (kind == KIND_ALLOC);

    // placement unit, one segment per cycle, works on the latched size
    mba_seg_walker #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IDX_W        (IDX_W)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (walk_go),
        .used     (used_reg),
        .size     (size_reg),
        .arena    (arena_reg),
        .seg_size (seg_size_reg),
        .res      (walk_res),
        .seg_idx  (walk_seg)
    );

    // one row of per-type counters for each level
    mba_cnt_mem #(
        .DEPTH (MAX_LEVELS),
        .WIDTH (ROW_W)
    ) u_cnt_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // a row never written since reset or since its mark reads as zero
    always_comb
    begin
        row_eff = row_valid_reg[mem_rd_addr] ? row_t'(mem_rd_data) : '0;
        cnt_sum = {1'b0, row_eff[lane_reg]} + {1'b0, size_reg};
        cnt_new = cnt_sum[32] ? CNT_MAX : cnt_sum[31:0];
        mem_wr_data           = row_eff;
        mem_wr_data[lane_reg] = cnt_new;
    end

    assign mem_rd_en   = (state_reg == S_CREAD) || (state_reg == S_QREAD);
    assign mem_rd_addr = (state_reg == S_QREAD || state_reg == S_QDONE) ? qlvl_reg : cur_lvl_reg;
    assign mem_wr_en   = (state_reg == S_CWRITE);
    assign mem_wr_addr = cur_lvl_reg;

    assign type_ok = (32'(mem_type) < MEM_TYPES);
    assign qlvl_ok = (32'(level) < MAX_LEVELS);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        arena_next     = arena_reg;
        seg_size_next  = seg_size_reg;
        used_next      = used_reg;
        cur_lvl_next   = cur_lvl_reg;
        row_valid_next = row_valid_reg;
        done_next      = 1'b0;
        size_next      = size_reg;
        lane_next      = lane_reg;
        qlvl_next      = qlvl_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        segment_next   = segment_reg;
        mlev_next      = mlev_reg;
        mused_next     = mused_reg;
        tbytes_next    = tbytes_reg;

        // config is to be written by the user only while idle; the block does not enforce it
        if (cfg_wr_en)
        begin
            if (cfg_index == CFG_ARENA_SIZE)
            begin
                arena_next = cfg_wdata;
            end
            else
            begin
                seg_size_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next    = size;
                    lane_next    = TYPE_W'(mem_type);
                    qlvl_next    = LVL_W'(level);
                    status_next  = ST_OK;
                    offset_next  = '0;
                    segment_next = '0;
                    mlev_next    = '0;
                    mused_next   = '0;
                    tbytes_next  = '0;
                    unique case (kind)
                        KIND_ALLOC:
                        begin
                            // keep only in-range types for the counter update
                            lane_next  = TYPE_W'(mem_type);
                            state_next = S_WALK;
                            qlvl_next  = type_ok ? {LVL_W{1'b0}} : {LVL_W{1'b1}};
                        end
                        KIND_MARK:
                        begin
                            mlev_next  = 4'(cur_lvl_reg);
                            mused_next = used_reg;
                            done_next  = 1'b1;
                            if (cur_lvl_reg == TOP_LEVEL)
                            begin
                                status_next = ST_LVL_OVF;
                            end
                            else
                            begin
                                // fresh level starts with cleared counters
                                cur_lvl_next                  = cur_lvl_reg + 1'b1;
                                row_valid_next[cur_lvl_next] = 1'b0;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            done_next = 1'b1;
                            if (32'(level) > 32'(cur_lvl_reg))
                            begin
                                status_next = ST_BAD_LEVEL;
                            end
                            else
                            begin
                                used_next    = mark_used;
                                cur_lvl_next = LVL_W'(level);
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (qlvl_ok && type_ok)
                            begin
                                state_next = S_QREAD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_res.done)
                begin
                    if (walk_res.ok)
                    begin
                        used_next    = walk_res.where + size_reg;
                        offset_next  = walk_res.where;
                        segment_next = 3'(walk_seg);
                        // all-ones marks a type with no counter
                        if (qlvl_reg == {LVL_W{1'b0}})
                        begin
                            state_next = S_CREAD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = ST_NO_MEM;
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                    end
                end
            end
            S_CREAD:
            begin
                state_next = S_CWRITE;
            end
            S_CWRITE:
            begin
                // saturating add lands in the row, row becomes valid
                row_valid_next[cur_lvl_reg] = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_QREAD:
            begin
                state_next = S_QDONE;
            end
            S_QDONE:
            begin
                tbytes_next = row_eff[lane_reg];
                state_next  = S_IDLE;
                done_next   = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arena_reg     <= ARENA_SIZE_RST;
            seg_size_reg  <= SEGMENT_SIZE_RST;
            used_reg      <= '0;
            cur_lvl_reg   <= '0;
            row_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arena_reg     <= arena_next;
            seg_size_reg  <= seg_size_next;
            used_reg      <= used_next;
            cur_lvl_reg   <= cur_lvl_next;
            row_valid_reg <= row_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        lane_reg    <= lane_next;
        qlvl_reg    <= qlvl_next;
        status_reg  <= status_next;
        offset_reg  <= offset_next;
        segment_reg <= segment_next;
        mlev_reg    <= mlev_next;
        mused_reg   <= mused_next;
        tbytes_reg  <= tbytes_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign offset       = offset_reg;
    assign segment      = segment_reg;
    assign marker_level = mlev_reg;
    assign marker_used  = mused_reg;
    assign type_bytes   = tbytes_reg;

    // placement results only show up while the sequencer waits for them
    a_walk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_res.done |-> (state_reg == S_WALK))
        else $error("placement result outside walk");

    // mark and release answer in the next cycle
    a_fast_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_MARK || kind == KIND_RELEASE)) |=> done)
        else $error("mark or release result missing");

    // leaving a long command always delivers its transfer
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // current level stays inside the counter memory
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_lvl_reg) < MAX_LEVELS))
        else $error("current level out of range");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the marked bump arena allocator: a directed table
// of commands and register writes, then random phases over several arena and
// segment settings, every result checked against a hand-written value or an in-bench arena model
// ----------------------------------------------------------------------------
module tb_top;
    import mba_pkg::*;

    localparam int LEVELS   = DEF_MAX_LEVELS;
    localparam int SEGMENTS = DEF_MAX_SEGMENTS;
    localparam int TYPES    = DEF_MEM_TYPES;

    localparam int PHASES     = 10;
    localparam int PHASE_CMDS = 128;
    localparam int PLAN_LEN   = 27;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] size;
        logic [2:0]  mem_type;
        logic [3:0]  level;
        logic [31:0] mark_used;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] offset;
        logic [2:0]  segment;
        logic [3:0]  marker_level;
        logic [31:0] marker_used;
        logic [31:0] type_bytes;
    } res_t;

    // one row of the directed table: either a register write or a command,
    // repeated reps times, with an optional hand-written expected result
    typedef struct packed {
        logic        is_cfg;
        logic        cfg_sel;
        logic [31:0] cfg_val;
        cmd_t        cmd;
        logic [4:0]  reps;
        logic        typed;
        res_t        want;
    } plan_row_t;

    localparam res_t ZERO = '0;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] size;
    logic [2:0]  mem_type;
    logic [3:0]  level;
    logic [31:0] mark_used;
    logic        done;
    logic [1:0]  status;
    logic [31:0] offset;
    logic [2:0]  segment;
    logic [3:0]  marker_level;
    logic [31:0] marker_used;
    logic [31:0] type_bytes;

    marked_bump_arena_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .size         (size),
        .mem_type     (mem_type),
        .level        (level),
        .mark_used    (mark_used),
        .done         (done),
        .status       (status),
        .offset       (offset),
        .segment      (segment),
        .marker_level (marker_level),
        .marker_used  (marker_used),
        .type_bytes   (type_bytes)
    );

    // bench copy of the allocator state and its two registers
    logic [31:0] arena_cfg;
    logic [31:0] segment_cfg;
    logic [31:0] used_q;
    int unsigned cur_level;
    logic [31:0] byte_count [LEVELS][TYPES];
    // used count reported by the last mark taken at each level, so random
    // releases can mostly restore a sensible bump pointer
    logic [31:0] mark_save [LEVELS];

    res_t expected_results [$];
    int   mismatches;

    plan_row_t plan [0:PLAN_LEN-1];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run of roughly half a millisecond
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // find where an alloc lands: align up, then walk the segments in order,
    // skipping the tail of any segment too small to hold the block
    function automatic logic place_block(input logic [31:0] req,
                                         output logic [31:0] at,
                                         output logic [2:0] seg_idx);
        logic [63:0] pos;
        logic [63:0] seg_lo;
        logic [63:0] seg_hi;
        logic [63:0] arena;
        logic        found;
        logic        past_end;
        pos      = ({32'd0, used_q} + {32'd0, ALIGN_MASK}) & ~{32'd0, ALIGN_MASK};
        arena    = {32'd0, arena_cfg};
        found    = 1'b0;
        past_end = 1'b0;
        at       = '0;
        seg_idx  = '0;
        if (segment_cfg == 32'd0)
        begin
            if (pos + {32'd0, req} <= arena)
            begin
                found = 1'b1;
                at    = pos[31:0];
            end
        end
        else
        begin
            for (int i = 0; i < SEGMENTS; i++)
            begin
                if (!found && !past_end)
                begin
                    seg_lo = {32'd0, segment_cfg} * 64'(i);
                    seg_hi = seg_lo + {32'd0, segment_cfg};
                    if (seg_lo >= arena)
                        past_end = 1'b1;
                    else
                    begin
                        if (seg_hi > arena)
                            seg_hi = arena;
                        if (pos < seg_lo)
                            pos = seg_lo;
                        if (pos < seg_hi)
                        begin
                            if ({32'd0, req} <= seg_hi - pos)
                            begin
                                found   = 1'b1;
                                at      = pos[31:0];
                                seg_idx = 3'(i);
                            end
                            else
                                pos = seg_hi;
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    // apply one accepted command to the bench state and form its result
    task automatic arena_predict(input cmd_t c, output res_t r);
        logic [31:0] at;
        logic [2:0]  seg_idx;
        r = ZERO;
        case (c.kind)
            KIND_ALLOC:
            begin
                if (place_block(c.size, at, seg_idx))
                begin
                    used_q    = at + c.size;
                    r.offset  = at;
                    r.segment = seg_idx;
                    // bad memory type still allocates but counts nothing
                    if (c.mem_type < TYPES)
                    begin
                        if (byte_count[cur_level][c.mem_type] > CNT_MAX - c.size)
                            byte_count[cur_level][c.mem_type] = CNT_MAX;
                        else
                            byte_count[cur_level][c.mem_type] += c.size;
                    end
                end
                else
                    r.status = ST_NO_MEM;
            end
            KIND_MARK:
            begin
                r.marker_level = 4'(cur_level);
                r.marker_used  = used_q;
                if (cur_level + 1 >= LEVELS)
                    r.status = ST_LVL_OVF;
                else
                begin
                    mark_save[cur_level] = used_q;
                    cur_level++;
                    for (int t = 0; t < TYPES; t++)
                        byte_count[cur_level][t] = '0;
                end
            end
            KIND_RELEASE:
            begin
                if (c.level > cur_level)
                    r.status = ST_BAD_LEVEL;
                else
                begin
                    used_q    = c.mark_used;
                    cur_level = c.level;
                end
            end
            default:
            begin
                // levels above the current one still read their stale counts
                if (c.mem_type < TYPES)
                    r.type_bytes = byte_count[c.level][c.mem_type];
            end
        endcase
    endtask

    // drive one command from a falling edge and hold it until the transfer
    task automatic issue_cmd(input cmd_t c, input logic typed, input res_t want);
        res_t model_r;
        @(negedge clk);
        start     = 1'b1;
        kind      = c.kind;
        size      = c.size;
        mem_type  = c.mem_type;
        level     = c.level;
        mark_used = c.mark_used;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        arena_predict(c, model_r);
        expected_results.push_back(typed ? want : model_r);
    endtask

    task automatic idle_sender(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // hold off new commands until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] val);
        drain();
        cfg_wr_en = 1'b1;
        cfg_index = sel;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (sel == CFG_ARENA_SIZE)
            arena_cfg = val;
        else
            segment_cfg = val;
    endtask

    // mostly well-formed traffic: allocs sized to the arena and segments,
    // releases back to levels that were really marked, queries of live levels
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        c.kind      = KIND_ALLOC;
        c.size      = $urandom();
        c.mem_type  = 3'($urandom_range(0, 7));
        c.level     = 4'($urandom_range(0, 15));
        c.mark_used = $urandom();
        pick        = $urandom_range(0, 99);
        if (pick < 50)
        begin
            c.kind = KIND_ALLOC;
            if ($urandom_range(0, 9) != 0)
                c.mem_type = 3'($urandom_range(0, TYPES - 1));
            case ($urandom_range(0, 9))
                0:       c.size = 32'd0;
                1, 2, 3: c.size = $urandom_range(0, 300);
                4, 5:    c.size = (segment_cfg != 0) ? $urandom_range(0, segment_cfg)
                                                     : $urandom_range(0, arena_cfg >> 6);
                6, 7:    c.size = $urandom_range(0, arena_cfg >> 3);
                default: c.size = $urandom();
            endcase
        end
        else if (pick < 65)
            c.kind = KIND_MARK;
        else if (pick < 77)
        begin
            c.kind = KIND_RELEASE;
            if ($urandom_range(0, 9) < 7)
            begin
                c.level     = 4'($urandom_range(0, cur_level));
                c.mark_used = mark_save[c.level];
            end
            else if ($urandom_range(0, 1) == 0)
                c.mark_used = $urandom_range(0, 4096);
        end
        else
        begin
            c.kind = KIND_QUERY;
            if ($urandom_range(0, 3) != 0)
                c.level = 4'($urandom_range(0, cur_level));
        end
        return c;
    endfunction

    // compare one field of a result against its expected value
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // results cannot be stalled: take one on every edge where done is high
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("status", 32'(exp_r.status), 32'(status));
                check_field("offset", exp_r.offset, offset);
                check_field("segment", 32'(exp_r.segment), 32'(segment));
                check_field("marker_level", 32'(exp_r.marker_level), 32'(marker_level));
                check_field("marker_used", exp_r.marker_used, marker_used);
                check_field("type_bytes", exp_r.type_bytes, type_bytes);
            end
        end
    end

    initial
    begin
        logic [31:0] phase_arena [PHASES];
        logic [31:0] phase_seg [PHASES];
        cmd_t        c;
        logic        quiet;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_ARENA_SIZE;
        cfg_wdata   = '0;
        start       = 1'b0;
        kind        = KIND_ALLOC;
        size        = '0;
        mem_type    = '0;
        level       = '0;
        mark_used   = '0;
        mismatches  = 0;
        arena_cfg   = ARENA_SIZE_RST;
        segment_cfg = SEGMENT_SIZE_RST;
        used_q      = '0;
        cur_level   = 0;
        for (int l = 0; l < LEVELS; l++)
        begin
            mark_save[l] = '0;
            for (int t = 0; t < TYPES; t++)
                byte_count[l][t] = '0;
        end

        // directed table, starting from the reset registers
        // is_cfg, reg, value, {kind, size, mem_type, level, mark_used}, reps, typed,
        //     {status, offset, segment, marker_level, marker_used, type_bytes}
        plan = '{
            // fresh counters read as zero
            '{1'b0, 1'b0, 32'd0, '{KIND_QUERY, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            // empty alloc at the bottom of the arena
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd100, 3'd1, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            // 100 rounds up to the next 32-byte boundary
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd1, 3'd2, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd128, 3'd0, 4'd0, 32'd0, 32'd0}},
            '{1'b0, 1'b0, 32'd0, '{KIND_QUERY, 32'd0, 3'd1, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'd100}},
            // largest request cannot fit
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'hFFFF_FFFF, 3'd0, 4'd0, 32'd0}, 5'd1,
                1'b1, '{ST_NO_MEM, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            // bad memory type allocates without counting
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd32, 3'd7, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd160, 3'd0, 4'd0, 32'd0, 32'd0}},
            '{1'b0, 1'b0, 32'd0, '{KIND_QUERY, 32'd0, 3'd7, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            '{1'b0, 1'b0, 32'd0, '{KIND_QUERY, 32'd0, 3'd5, 4'd15, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            '{1'b0, 1'b0, 32'd0, '{KIND_MARK, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd192, 32'd0}},
            // release above the current level is refused
            '{1'b0, 1'b0, 32'd0, '{KIND_RELEASE, 32'd0, 3'd0, 4'd5, 32'd0}, 5'd1, 1'b1,
                '{ST_BAD_LEVEL, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            // climb to the top level, then overflow it
            '{1'b0, 1'b0, 32'd0, '{KIND_MARK, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd14, 1'b0,
                ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_MARK, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_LVL_OVF, 32'd0, 3'd0, 4'd15, 32'd192, 32'd0}},
            // restored used count at the very top: alignment carries past 32 bits
            '{1'b0, 1'b0, 32'd0, '{KIND_RELEASE, 32'd0, 3'd0, 4'd0, 32'hFFFF_FFFF}, 5'd1,
                1'b1, ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_NO_MEM, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}},
            // full arena, then saturate a counter by allocating twice
            '{1'b1, CFG_ARENA_SIZE, 32'hFFFF_FFFF, '0, 5'd0, 1'b0, ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_RELEASE, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'hFFFF_FFE0, 3'd3, 4'd0, 32'd0}, 5'd1,
                1'b1, ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_RELEASE, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'hFFFF_FFE0, 3'd3, 4'd0, 32'd0}, 5'd1,
                1'b1, ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_QUERY, 32'd0, 3'd3, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd0, 3'd0, 4'd0, 32'd0, 32'hFFFF_FFFF}},
            // five segments of 1000 bytes
            '{1'b1, CFG_SEGMENT_SIZE, 32'd1000, '0, 5'd0, 1'b0, ZERO},
            '{1'b1, CFG_ARENA_SIZE, 32'd5000, '0, 5'd0, 1'b0, ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_RELEASE, 32'd0, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                ZERO},
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd900, 3'd4, 4'd0, 32'd0}, 5'd1, 1'b1,
                ZERO},
            // does not fit the tail of segment 0, skips into segment 1
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd200, 3'd5, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_OK, 32'd1000, 3'd1, 4'd0, 32'd0, 32'd0}},
            // bigger than any segment
            '{1'b0, 1'b0, 32'd0, '{KIND_ALLOC, 32'd1001, 3'd0, 4'd0, 32'd0}, 5'd1, 1'b1,
                '{ST_NO_MEM, 32'd0, 3'd0, 4'd0, 32'd0, 32'd0}}
        };

        // random phases: the extremes of both registers, truncated last
        // segments, more segments than the walker covers, a random pair, and
        // a one-byte segment size
        phase_arena = '{ARENA_SIZE_RST, 32'hFFFF_FFFF, 32'd0, 32'd4096, 32'd5000,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1_000_000,
                         $urandom_range(0, 20000), ARENA_SIZE_RST};
        phase_seg   = '{32'd0, 32'd0, 32'd0, 32'd512, 32'd1000, 32'hFFFF_FFFF,
                        32'h2000_0000, 32'd100, $urandom_range(0, 3000), 32'd1};

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
                write_reg(plan[r].cfg_sel, plan[r].cfg_val);
            else
            begin
                for (int n = 0; n < plan[r].reps; n++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        idle_sender($urandom_range(1, 11));
                    issue_cmd(plan[r].cmd, plan[r].typed, plan[r].want);
                end
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_ARENA_SIZE, phase_arena[p]);
            write_reg(CFG_SEGMENT_SIZE, phase_seg[p]);
            quiet = 1'b0;
            for (int i = 0; i < PHASE_CMDS; i++)
            begin
                // sender gaps come and go in stretches; none in the last phase
                if (i % 32 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if (p != PHASES - 1)
                begin
                    if ($urandom_range(0, 39) == 0)
                        drain();
                    else if (!quiet && $urandom_range(0, 4) == 0)
                        idle_sender($urandom_range(1, 11));
                end
                c = random_cmd();
                issue_cmd(c, 1'b0, ZERO);
            end
        end

        drain();
        // margin for a walk plus counter update before the final check
        repeat (SEGMENTS + 8)
            @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
